// ----- hw/rtl/pida_pkg.sv -----
// shared types and codes for the positional insert/delete array
package pida_pkg;

  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_RDWAIT,
    S_SHIFT
  } state_t;

  typedef struct packed {
    logic load;      // capture a new beat
    logic rd_en;     // memory read at the address the datapath selects
    logic wr_shift;  // write the fetched entry one place over and step the index
    logic finish;    // final write / count update for insert and delete
    logic emit;      // present the result
    logic emit_rd;   // result carries the fetched entry
  } cmd_t;

  typedef struct packed {
    logic ok;
    logic is_read;
    logic is_ins;
    logic is_del;
    logic more;      // another entry still has to move
  } stat_t;

endpackage

// ----- hw/rtl/pida_ctrl.sv -----
// controller state machine for the positional insert/delete array
module pida_ctrl import pida_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  stat_t stat,
  output logic  busy,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!stat.ok) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end else if (stat.is_read) begin
          cmd.rd_en = 1'b1;
          state_nxt = S_RDWAIT;
        end else if (stat.more) begin
          cmd.rd_en = 1'b1;
          state_nxt = S_SHIFT;
        end else begin
          cmd.finish = 1'b1;
          cmd.emit   = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_RDWAIT: begin
        cmd.emit    = 1'b1;
        cmd.emit_rd = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_SHIFT: begin
        cmd.wr_shift = 1'b1;
        state_nxt    = S_EVAL;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/pida_datapath.sv -----
// entry memory, count, shift index and result registers
module pida_datapath import pida_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  input  logic        [1:0]  in_opcode,
  input  logic signed [31:0] in_value,
  input  logic        [5:0]  in_position,
  output stat_t              stat,
  output logic               out_valid,
  output logic        [1:0]  out_status,
  output logic signed [31:0] out_read_value,
  output logic        [6:0]  out_count
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [31:0] mem [CAPACITY];

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [1:0]    op_r;
  logic [31:0]   val_r;
  logic [5:0]    pos_r;
  logic [1:0]    status_r, status_nxt;
  logic [31:0]   rdata_r;

  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [31:0]   out_rd_r;
  logic [6:0]    out_count_r;

  // position and count compared at a common width
  logic [CW+5:0] in_pos_w, pos_w, cnt_w, idx_w;
  logic [CW-1:0] in_pos_c;
  logic [AW+5:0] pos_a_w;
  logic [CW-1:0] idx_dn, idx_up;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  logic [31:0]   wr_data;
  logic [CW+6:0] cnt_ext;

  assign in_pos_w = {{CW{1'b0}}, in_position};
  assign pos_w    = {{CW{1'b0}}, pos_r};
  assign cnt_w    = {6'b0, count_r};
  assign idx_w    = {6'b0, idx_r};
  assign in_pos_c = in_pos_w[CW-1:0];
  assign pos_a_w  = {{AW{1'b0}}, pos_r};
  assign idx_dn   = idx_r - CW'(1);
  assign idx_up   = idx_r + CW'(1);

  always_comb begin
    case (in_opcode)
      OP_READ:   status_nxt = (in_pos_w < cnt_w) ? ST_OK : ST_BADPOS;
      OP_INSERT: begin
        if (count_r >= CAP_C)      status_nxt = ST_FULL;
        else if (in_pos_w > cnt_w) status_nxt = ST_BADPOS;
        else                       status_nxt = ST_OK;
      end
      OP_DELETE: begin
        if (count_r == '0)          status_nxt = ST_EMPTY;
        else if (in_pos_w >= cnt_w) status_nxt = ST_BADPOS;
        else                        status_nxt = ST_OK;
      end
      default:   status_nxt = ST_BADPOS;
    endcase
  end

  assign stat.ok      = (status_r == ST_OK);
  assign stat.is_read = (op_r == OP_READ);
  assign stat.is_ins  = (op_r == OP_INSERT);
  assign stat.is_del  = (op_r == OP_DELETE);
  assign stat.more    = stat.is_ins ? (idx_w > pos_w)
                                    : ({6'b0, idx_up} < cnt_w);

  always_comb begin
    case (op_r)
      OP_INSERT: rd_addr = idx_dn[AW-1:0];
      OP_DELETE: rd_addr = idx_up[AW-1:0];
      default:   rd_addr = pos_a_w[AW-1:0];
    endcase
  end

  // shift writes fetched entry at index; insert finish writes value
  always_comb begin
    wr_en   = cmd.wr_shift || (cmd.finish && stat.is_ins);
    wr_addr = cmd.wr_shift ? idx_r[AW-1:0] : pos_a_w[AW-1:0];
    wr_data = cmd.wr_shift ? rdata_r : val_r;
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.finish && stat.is_ins) count_nxt = count_r + CW'(1);
    if (cmd.finish && stat.is_del) count_nxt = count_r - CW'(1);
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.load) begin
      idx_nxt = (in_opcode == OP_INSERT) ? count_r : in_pos_c;
    end else if (cmd.wr_shift) begin
      idx_nxt = stat.is_ins ? idx_dn : idx_up;
    end
  end

  assign cnt_ext = {7'b0, count_nxt};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.load) begin
      op_r     <= in_opcode;
      val_r    <= in_value;
      pos_r    <= in_position;
      status_r <= status_nxt;
    end
    if (cmd.emit) begin
      out_status_r <= status_r;
      out_rd_r     <= cmd.emit_rd ? rdata_r : 32'd0;
      out_count_r  <= cnt_ext[6:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_rd_r;
  assign out_count      = out_count_r;

endmodule

// ----- hw/rtl/positional_insert_delete_array_core.sv -----
// positional insert/delete array: a refused beat or an insert/delete that moves nothing is
// settled in the evaluate state, a read passes through a read-wait state, and each entry
// moved (count - position for insert, count - position - 1 for delete) takes an evaluate
// state and a shift state; the entry memory has one read and one write port; busy drops
// with the strobe cycle, so the next beat is taken while the result is shown; the receiver
// cannot stall; synchronous reset clears the count and the strobe; entries are left unset
module positional_insert_delete_array_core import pida_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic        [1:0]  in_opcode,
  input  logic signed [31:0] in_value,
  input  logic        [5:0]  in_position,
  output logic               out_valid,
  output logic        [1:0]  out_status,
  output logic signed [31:0] out_read_value,
  output logic        [6:0]  out_count
);

  cmd_t  cmd;
  stat_t stat;

  pida_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  pida_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_opcode      (in_opcode),
    .in_value       (in_value),
    .in_position    (in_position),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_count      (out_count)
  );

endmodule
